@@ sv/cbum_pkg.sv @@
// ----------------------------------------------------------------------------
// Usage map package
// Shared widths, result codes and the controller/datapath command and status
// groups of the contiguous block usage map.
// ----------------------------------------------------------------------------
package cbum_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int BLK_W      = $clog2(MAX_BLOCKS);
   localparam int SIZE_W     = BLK_W + 1;
   localparam int WORD_W     = 16;
   localparam int BIT_SEL_W  = $clog2(WORD_W);
   localparam int NUM_WORDS  = MAX_BLOCKS / WORD_W;
   localparam int ADDR_W     = $clog2(NUM_WORDS);
   localparam int HALF_W     = WORD_W / 2;
   localparam int HALF_SEL_W = $clog2(HALF_W);

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BOUNDS    = 2'd1,
      ST_IN_USE    = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      KIND_MARK = 1'b0,
      KIND_FIND = 1'b1
   } kind_type;

   typedef struct packed {
      logic       load;
      logic       rd;
      logic       step;
      logic       rewind;
      logic       find_step;
      logic       write;
      logic       set_res;
      status_type res_code;
      logic       use_hit;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic is_find;
      logic size_zero;
      logic bad_bounds;
      logic empty_range;
      logic make_free;
      logic last_word;
      logic used_hit;
      logic hit;
      logic half_hi;
      logic out_free;
   } sts_type;

endpackage

@@ sv/cbum_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one mark or find request word.
// ----------------------------------------------------------------------------
interface cbum_req_if;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [cbum_pkg::BLK_W-1:0]  first_block;
   logic [cbum_pkg::SIZE_W-1:0] end_block;
   logic                      mark_free;
   logic [cbum_pkg::SIZE_W-1:0] required_count;

   modport source (output valid, kind, first_block, end_block, mark_free,
                   required_count, input ready);
   modport sink   (input valid, kind, first_block, end_block, mark_free,
                   required_count, output ready);
endinterface

@@ sv/cbum_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface cbum_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 status;
   logic [cbum_pkg::BLK_W-1:0] found_start;

   modport source (output valid, status, found_start, input ready);
   modport sink   (input valid, status, found_start, output ready);
endinterface

@@ sv/contiguous_block_usage_map.sv @@
// ----------------------------------------------------------------------------
// Contiguous block usage map
// Free/used mark per storage block with range marking and first-fit search.
//
//   channel   dir   handshake      contents
//   req_bus   in    valid/ready    kind, first_block, end_block, mark_free,
//                                  required_count
//   rsp_bus   out   valid/ready    status, found_start
//   csr_*     in    write enable   map_size
//
// Mark free: one write pass over the map words covered by the range.
// Mark used: check pass then write pass, one word a cycle.
// Find: scans the map words in order from word 0, one half word per cycle.
// One request in flight; the next is taken once the result is registered.
// Reset is synchronous and clears all marks at once through per-word flags.
// A stalled result holds in the output register; the block then takes one more
// request and holds its result until the output register is free.
// ----------------------------------------------------------------------------
module contiguous_block_usage_map (
   input  logic                        clock,
   input  logic                        reset,
   cbum_req_if.sink                    req_bus,
   cbum_rsp_if.source                  rsp_bus,
   input  logic                        csr_we,
   input  logic [cbum_pkg::SIZE_W-1:0] csr_wdata
);

   logic [cbum_pkg::SIZE_W-1:0] map_size_ff;
   cbum_pkg::cmd_type           cmd;
   cbum_pkg::sts_type           sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff <= cbum_pkg::SIZE_W'(cbum_pkg::MAX_BLOCKS);
      end else if (csr_we) begin
         map_size_ff <= csr_wdata;
      end
   end

   cbum_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cbum_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .map_size           (map_size_ff),
      .req_kind           (req_bus.kind),
      .req_first_block    (req_bus.first_block),
      .req_end_block      (req_bus.end_block),
      .req_mark_free      (req_bus.mark_free),
      .req_required_count (req_bus.required_count),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_status         (rsp_bus.status),
      .rsp_found_start    (rsp_bus.found_start)
   );

endmodule

@@ sv/cbum_ctrl.sv @@
// ----------------------------------------------------------------------------
// Usage map controller
// Sequences bounds check, used-range check, write pass and first-fit scan.
// ----------------------------------------------------------------------------
module cbum_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbum_pkg::sts_type sts,
   output cbum_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_FIND,
      S_CHECK,
      S_WRITE,
      S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      cmd.res_code = cbum_pkg::ST_OK;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (sts.is_find) begin
               if (sts.size_zero) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = cbum_pkg::ST_NOT_FOUND;
                  state_in     = S_RESP;
               end else begin
                  cmd.rd   = 1'b1;
                  state_in = S_FIND;
               end
            end else if (sts.bad_bounds) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = cbum_pkg::ST_BOUNDS;
               state_in     = S_RESP;
            end else if (sts.empty_range) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = cbum_pkg::ST_OK;
               state_in     = S_RESP;
            end else begin
               cmd.rd   = 1'b1;
               state_in = sts.make_free ? S_WRITE : S_CHECK;
            end
         end
         S_FIND: begin
            cmd.find_step = 1'b1;
            if (sts.hit) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = cbum_pkg::ST_OK;
               cmd.use_hit  = 1'b1;
               state_in     = S_RESP;
            end else if (sts.half_hi) begin
               if (sts.last_word) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = cbum_pkg::ST_NOT_FOUND;
                  state_in     = S_RESP;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         S_CHECK: begin
            if (sts.used_hit) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = cbum_pkg::ST_IN_USE;
               state_in     = S_RESP;
            end else if (sts.last_word) begin
               cmd.rewind = 1'b1;
               state_in   = S_WRITE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            if (sts.last_word) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = cbum_pkg::ST_OK;
               state_in     = S_RESP;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/cbum_datapath.sv @@
// ----------------------------------------------------------------------------
// Usage map datapath
// Map memory of 16-bit words with per-word valid bits, range masks, run
// tracking for the first-fit scan, result and output registers.
// ----------------------------------------------------------------------------
module cbum_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  cbum_pkg::cmd_type               cmd,
   output cbum_pkg::sts_type               sts,
   input  logic [cbum_pkg::SIZE_W-1:0]     map_size,
   input  logic                            req_kind,
   input  logic [cbum_pkg::BLK_W-1:0]      req_first_block,
   input  logic [cbum_pkg::SIZE_W-1:0]     req_end_block,
   input  logic                            req_mark_free,
   input  logic [cbum_pkg::SIZE_W-1:0]     req_required_count,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic [cbum_pkg::BLK_W-1:0]      rsp_found_start
);

   // request and scan registers
   logic                                kind_ff;
   logic [cbum_pkg::BLK_W-1:0]          first_ff;
   logic [cbum_pkg::SIZE_W-1:0]         end_ff;
   logic                                free_ff;
   logic [cbum_pkg::SIZE_W-1:0]         need_ff;
   logic [cbum_pkg::SIZE_W-1:0]         eff_ff, eff_in;
   logic [cbum_pkg::ADDR_W-1:0]         word_ff, word_in;
   logic                                half_ff;
   logic [cbum_pkg::SIZE_W-1:0]         run_ff, run_in;
   logic [cbum_pkg::BLK_W-1:0]          run_start_ff, run_start_in;

   // map memory
   logic [cbum_pkg::WORD_W-1:0]         mem [cbum_pkg::NUM_WORDS];
   logic [cbum_pkg::NUM_WORDS-1:0]      mem_valid_ff;
   logic [cbum_pkg::WORD_W-1:0]         rd_mem_ff;
   logic                                rd_valid_ff;
   logic [cbum_pkg::WORD_W-1:0]         rd_word;
   logic                                rd_en;
   logic [cbum_pkg::ADDR_W-1:0]         rd_addr;

   // masks and results
   logic [cbum_pkg::ADDR_W-1:0]         first_word, last_word;
   logic [cbum_pkg::SIZE_W-1:0]         lim;
   logic [cbum_pkg::WORD_W-1:0]         lo_mask, hi_mask, mask, wr_word;
   logic                                hit;
   logic [cbum_pkg::BLK_W-1:0]          hit_start;
   cbum_pkg::status_type                res_status_ff;
   logic [cbum_pkg::BLK_W-1:0]          res_start_ff;
   logic                                rsp_valid_ff;
   logic [1:0]                          rsp_status_ff;
   logic [cbum_pkg::BLK_W-1:0]          rsp_start_ff;

   // clamp map size to the map depth
   assign eff_in = (map_size > cbum_pkg::SIZE_W'(cbum_pkg::MAX_BLOCKS))
                   ? cbum_pkg::SIZE_W'(cbum_pkg::MAX_BLOCKS) : map_size;

   assign first_word = first_ff[cbum_pkg::BLK_W-1:cbum_pkg::BIT_SEL_W];
   assign lim        = kind_ff ? (eff_ff - 1'b1) : (end_ff - 1'b1);
   assign last_word  = lim[cbum_pkg::BLK_W-1:cbum_pkg::BIT_SEL_W];

   assign lo_mask = (word_ff == first_word)
                    ? ({cbum_pkg::WORD_W{1'b1}} << first_ff[cbum_pkg::BIT_SEL_W-1:0])
                    : {cbum_pkg::WORD_W{1'b1}};
   assign hi_mask = (word_ff == last_word)
                    ? ({cbum_pkg::WORD_W{1'b1}} >>
                       (cbum_pkg::BIT_SEL_W'(cbum_pkg::WORD_W - 1) -
                        lim[cbum_pkg::BIT_SEL_W-1:0]))
                    : {cbum_pkg::WORD_W{1'b1}};
   assign mask    = lo_mask & hi_mask;

   assign rd_word = rd_valid_ff ? rd_mem_ff : '0;
   assign wr_word = free_ff ? (rd_word & ~mask) : (rd_word | mask);

   assign rd_en   = cmd.rd | cmd.step | cmd.rewind;
   assign rd_addr = cmd.rewind ? first_word : (cmd.step ? word_ff + 1'b1 : word_ff);

   // walk one half word of the scan
   always_comb begin
      logic [cbum_pkg::SIZE_W-1:0]        run_v;
      logic [cbum_pkg::BLK_W-1:0]         st_v;
      logic [cbum_pkg::BLK_W-1:0]         idx;
      logic                               used;
      run_v     = run_ff;
      st_v      = run_start_ff;
      hit       = 1'b0;
      hit_start = '0;
      for (int k = 0; k < cbum_pkg::HALF_W; k++) begin
         idx  = {word_ff, half_ff, cbum_pkg::HALF_SEL_W'(k)};
         used = rd_word[{half_ff, cbum_pkg::HALF_SEL_W'(k)}];
         if (!hit && ({1'b0, idx} < eff_ff)) begin
            if (!used) begin
               if (run_v == '0) begin
                  st_v = idx;
               end
               run_v = run_v + 1'b1;
            end else begin
               run_v = '0;
            end
            if (run_v == need_ff) begin
               hit       = 1'b1;
               hit_start = st_v;
            end
         end
      end
      run_in       = run_v;
      run_start_in = st_v;
   end

   always_comb begin
      word_in = word_ff;
      if (cmd.load) begin
         word_in = (req_kind == cbum_pkg::KIND_FIND) ? '0
                   : req_first_block[cbum_pkg::BLK_W-1:cbum_pkg::BIT_SEL_W];
      end else if (cmd.rewind) begin
         word_in = first_word;
      end else if (cmd.step) begin
         word_in = word_ff + 1'b1;
      end
   end

   always_comb begin
      sts             = '0;
      sts.is_find     = kind_ff;
      sts.size_zero   = (eff_ff == '0);
      sts.bad_bounds  = (end_ff >= eff_ff) || ({1'b0, first_ff} > end_ff);
      sts.empty_range = ({1'b0, first_ff} == end_ff);
      sts.make_free   = free_ff;
      sts.last_word   = (word_ff == last_word);
      sts.used_hit    = |(rd_word & mask);
      sts.hit         = hit;
      sts.half_hi     = half_ff;
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         first_ff <= req_first_block;
         end_ff   <= req_end_block;
         free_ff  <= req_mark_free;
         need_ff  <= req_required_count;
         eff_ff   <= eff_in;
      end
      word_ff <= word_in;
      if (cmd.load) begin
         half_ff      <= 1'b0;
         run_ff       <= '0;
         run_start_ff <= '0;
      end else if (cmd.find_step) begin
         half_ff      <= ~half_ff;
         run_ff       <= run_in;
         run_start_ff <= run_start_in;
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_code;
         res_start_ff  <= cmd.use_hit ? hit_start : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[word_ff] <= wr_word;
      end
      if (rd_en) begin
         rd_mem_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.write) begin
            mem_valid_ff[word_ff] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= mem_valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_start_ff  <= res_start_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_start = rsp_start_ff;

   a_no_write_on_find: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> !kind_ff)
      else $error("map written during a find");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result word overwritten before it was taken");

   a_bounds_reason: assert property (@(posedge clock) disable iff (reset)
      (cmd.set_res && cmd.res_code == cbum_pkg::ST_BOUNDS) |-> sts.bad_bounds)
      else $error("bounds rejection without a bounds fault");

   a_hit_backed: assert property (@(posedge clock) disable iff (reset)
      cmd.use_hit |-> (hit && kind_ff))
      else $error("run start taken without a hit");

   a_write_after_check: assert property (@(posedge clock) disable iff (reset)
      (cmd.set_res && cmd.res_code == cbum_pkg::ST_IN_USE) |=> !cmd.write)
      else $error("write after an in-use rejection");

endmodule
